@@ sv/stirr_pkg.sv @@
// Shared types and codes for the rate table interpolator.
`default_nettype none
package stirr_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_SCALE       = 2'd1;
    localparam logic [1:0] REG_SHIFT       = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // word class carried down the pipe
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_RANGE = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    // divider: dividend = 16b energy step * 32b rate step, divisor = 16b energy span
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 16;

    typedef struct packed {
        logic        op;
        logic [5:0]  point_index;
        logic [15:0] point_energy;
        logic [31:0] point_rate;
        logic [15:0] eval_energy;
        logic [31:0] electron_density;
        logic [31:0] o2_concentration;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rate_coefficient;
        logic [63:0] reaction_progress;
    } out_word_t;

    // control and payload riding alongside the divider
    typedef struct packed {
        logic        vld;
        logic [1:0]  kind;
        logic        base;   // rate is the left point's rate, no interpolation
        logic        neg;    // rate step is negative
        logic [31:0] ya;
        logic [31:0] dens;
        logic [63:0] b;      // concentration * scale
    } side_t;

endpackage
`default_nettype wire

@@ sv/stirr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module stirr_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [stirr_pkg::DIV_NW-1:0]  num,
    input  wire logic [stirr_pkg::DIV_DW-1:0]  den,
    input  wire stirr_pkg::side_t              side_in,
    output logic      [stirr_pkg::DIV_NW-1:0]  quo,
    output stirr_pkg::side_t                   side_out
);

    localparam int NW = stirr_pkg::DIV_NW;
    localparam int DW = stirr_pkg::DIV_DW;

    logic [NW-1:0]      acc_reg  [NW];
    logic [DW-1:0]      rem_reg  [NW];
    logic [DW-1:0]      den_reg  [NW];
    stirr_pkg::side_t   side_reg [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [NW-1:0]    acc_in;
        logic [DW-1:0]    rem_in;
        logic [DW-1:0]    den_in;
        stirr_pkg::side_t side_s;
        logic [DW:0]      trial;
        logic [DW:0]      diff;
        logic             take;
        logic [NW-1:0]    acc_next;
        logic [DW-1:0]    rem_next;

        if (s == 0) begin : g_first
            assign acc_in = num;
            assign rem_in = '0;
            assign den_in = den;
            assign side_s = side_in;
        end
        else begin : g_rest
            assign acc_in = acc_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign side_s = side_reg[s-1];
        end

        assign trial    = {rem_in, acc_in[NW-1]};
        assign diff     = trial - {1'b0, den_in};
        assign take     = (trial >= {1'b0, den_in});
        assign rem_next = take ? diff[DW-1:0] : trial[DW-1:0];
        assign acc_next = {acc_in[NW-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[s] <= '0;
            end
            else
            begin
                side_reg[s] <= side_s;
            end
        end

        always_ff @(posedge clk)
        begin
            acc_reg[s] <= acc_next;
            rem_reg[s] <= rem_next;
            den_reg[s] <= den_in;
        end
    end

    assign quo      = acc_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule
`default_nettype wire

@@ sv/strict_table_interp_reaction_rate.sv @@
// Top level: strict piecewise-linear rate table and reaction progress product.
`default_nettype none
// Usage
//   Command channel: a word on cmd is taken at each rising edge with start
//   high and busy low. busy is always low: the block is a fixed pipeline and
//   takes one word per cycle, every cycle.
//   op = load writes one table point (energy, rate) and returns an all-zero
//   word. op = evaluate looks up eval_energy, interpolates the rate, and
//   returns rate * density * concentration * scale_factor >> result_shift.
//   Result channel: result_valid strobes for one cycle per command word,
//   in command order. The pipeline depth is set by the divider (one
//   quotient bit per stage over a 48-bit dividend) plus table search,
//   table read and the 64x64 product stages.
//   Throughput is one word per cycle.
//   Config: cfg_we writes point_count, scale_factor or result_shift at the
//   edge; write only while no command is in flight. Reset clears the pipe
//   valids and presets config registers. Table contents are undefined until
//   loaded. The receiver cannot stall; results are never held.
module strict_table_interp_reaction_rate #(
    parameter int TABLE_POINTS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire stirr_pkg::in_word_t  cmd,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    output logic                      result_valid,
    output stirr_pkg::out_word_t      result
);

    localparam int IW      = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
    localparam int NG      = (TABLE_POINTS + 7) / 8;
    localparam int LATENCY = 12 + stirr_pkg::DIV_NW;

    //------------------------------------------------------------------
    // Config registers
    //------------------------------------------------------------------
    logic [6:0]  pc_reg;
    logic [31:0] scale_reg;
    logic [5:0]  shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= 7'd2;
            scale_reg <= 32'd1;
            shift_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stirr_pkg::REG_POINT_COUNT: pc_reg    <= cfg_data[6:0];
                stirr_pkg::REG_SCALE:       scale_reg <= cfg_data;
                stirr_pkg::REG_SHIFT:       shift_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // points in use, clamped to 2..TABLE_POINTS
    logic [IW:0]   n_used;
    logic [IW:0]   nm2;
    logic [IW-1:0] nm1;

    always_comb
    begin
        if (pc_reg < 7'd2)
        begin
            n_used = (IW+1)'(2);
        end
        else if (int'(pc_reg) > TABLE_POINTS)
        begin
            n_used = (IW+1)'(TABLE_POINTS);
        end
        else
        begin
            n_used = (IW+1)'(pc_reg);
        end
    end

    assign nm1 = IW'(n_used - (IW+1)'(1));
    assign nm2 = n_used - (IW+1)'(2);

    assign busy = 1'b0;

    //------------------------------------------------------------------
    // S1: command register, compare against every table energy
    //------------------------------------------------------------------
    logic                s1_vld_reg;
    stirr_pkg::in_word_t s1_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd;
    end

    // energies kept in flops for the parallel compare; a load updates them
    // here so the very next word already sees the new point
    logic [15:0]             ecmp_reg [TABLE_POINTS];
    logic [TABLE_POINTS-1:0] ge_vec;
    logic [TABLE_POINTS-1:0] eq_vec;
    logic [TABLE_POINTS-1:0] mask_vec;
    logic                    s1_load;
    logic                    s1_wr_ok;

    assign s1_load  = s1_vld_reg && (s1_cmd_reg.op == stirr_pkg::OP_LOAD);
    assign s1_wr_ok = (int'(s1_cmd_reg.point_index) < TABLE_POINTS);

    always_ff @(posedge clk)
    begin
        if (s1_load && s1_wr_ok)
        begin
            ecmp_reg[IW'(s1_cmd_reg.point_index)] <= s1_cmd_reg.point_energy;
        end
    end

    for (genvar k = 0; k < TABLE_POINTS; k++) begin : g_cmp
        assign ge_vec[k]   = (ecmp_reg[k] <= s1_cmd_reg.eval_energy);
        assign eq_vec[k]   = (ecmp_reg[k] == s1_cmd_reg.eval_energy);
        assign mask_vec[k] = ge_vec[k] & ((IW+1)'(k) <= nm2);
    end

    //------------------------------------------------------------------
    // S2: bracket candidates, range flags, concentration * scale
    //------------------------------------------------------------------
    logic                    s2_vld_reg;
    stirr_pkg::in_word_t     s2_cmd_reg;
    logic [TABLE_POINTS-1:0] s2_mask_reg;
    logic                    s2_out_reg;
    logic                    s2_eq0_reg;
    logic                    s2_eql_reg;
    logic [63:0]             s2_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg  <= s1_cmd_reg;
        s2_mask_reg <= mask_vec;
        s2_out_reg  <= ~ge_vec[0] | (ge_vec[nm1] & ~eq_vec[nm1]);
        s2_eq0_reg  <= eq_vec[0];
        s2_eql_reg  <= eq_vec[nm1];
        s2_b_reg    <= 64'(s1_cmd_reg.o2_concentration) * 64'(scale_reg);
    end

    //------------------------------------------------------------------
    // S3: highest candidate inside each group of eight
    //------------------------------------------------------------------
    logic [NG*8-1:0] mask_pad;
    logic [NG-1:0]   grp_any;
    logic [2:0]      grp_off [NG];

    assign mask_pad = (NG*8)'(s2_mask_reg);

    for (genvar g = 0; g < NG; g++) begin : g_grp
        always_comb
        begin
            grp_off[g] = 3'd0;
            for (int j = 0; j < 8; j++)
            begin
                if (mask_pad[g*8+j])
                begin
                    grp_off[g] = 3'(j);
                end
            end
        end
        assign grp_any[g] = |mask_pad[g*8 +: 8];
    end

    logic                s3_vld_reg;
    stirr_pkg::in_word_t s3_cmd_reg;
    logic [NG-1:0]       s3_any_reg;
    logic [2:0]          s3_off_reg [NG];
    logic                s3_out_reg;
    logic                s3_eq0_reg;
    logic                s3_eql_reg;
    logic [63:0]         s3_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_cmd_reg <= s2_cmd_reg;
        s3_any_reg <= grp_any;
        s3_off_reg <= grp_off;
        s3_out_reg <= s2_out_reg;
        s3_eq0_reg <= s2_eq0_reg;
        s3_eql_reg <= s2_eql_reg;
        s3_b_reg   <= s2_b_reg;
    end

    //------------------------------------------------------------------
    // S4: bracket index, table read (loads write the table here too)
    //------------------------------------------------------------------
    logic [IW-1:0] idx_i;
    logic [IW-1:0] idx_a;
    logic [IW-1:0] idx_b;
    logic [1:0]    s4_kind;
    logic          s4_load;
    logic          s4_wr_ok;

    always_comb
    begin
        idx_i = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (s3_any_reg[g])
            begin
                idx_i = IW'(g * 8 + int'(s3_off_reg[g]));
            end
        end
    end

    assign idx_a = s3_eq0_reg ? '0 : (s3_eql_reg ? nm1 : idx_i);
    assign idx_b = IW'(32'(idx_i) + 32'd1);

    assign s4_load  = s3_vld_reg && (s3_cmd_reg.op == stirr_pkg::OP_LOAD);
    assign s4_wr_ok = (int'(s3_cmd_reg.point_index) < TABLE_POINTS);

    always_comb
    begin
        if (s3_cmd_reg.op == stirr_pkg::OP_LOAD)
        begin
            s4_kind = stirr_pkg::KIND_LOAD;
        end
        else if (s3_out_reg)
        begin
            s4_kind = stirr_pkg::KIND_RANGE;
        end
        else
        begin
            s4_kind = stirr_pkg::KIND_EVAL;
        end
    end

    logic [15:0] emem [TABLE_POINTS];
    logic [31:0] rmem [TABLE_POINTS];
    logic [15:0] s5_xa_reg;
    logic [15:0] s5_xb_reg;
    logic [31:0] s5_ya_reg;
    logic [31:0] s5_yb_reg;

    always_ff @(posedge clk)
    begin
        if (s4_load && s4_wr_ok)
        begin
            emem[IW'(s3_cmd_reg.point_index)] <= s3_cmd_reg.point_energy;
            rmem[IW'(s3_cmd_reg.point_index)] <= s3_cmd_reg.point_rate;
        end
        s5_xa_reg <= emem[idx_a];
        s5_xb_reg <= emem[idx_b];
        s5_ya_reg <= rmem[idx_a];
        s5_yb_reg <= rmem[idx_b];
    end

    logic        s5_vld_reg;
    logic [1:0]  s5_kind_reg;
    logic        s5_direct_reg;
    logic [15:0] s5_e_reg;
    logic [31:0] s5_dens_reg;
    logic [63:0] s5_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s5_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_kind_reg   <= s4_kind;
        s5_direct_reg <= s3_eq0_reg | s3_eql_reg;
        s5_e_reg      <= s3_cmd_reg.eval_energy;
        s5_dens_reg   <= s3_cmd_reg.electron_density;
        s5_b_reg      <= s3_b_reg;
    end

    //------------------------------------------------------------------
    // S5 -> S6: steps in energy and rate
    //------------------------------------------------------------------
    logic [16:0] dx;
    logic [32:0] dy;
    logic [32:0] dy_neg;
    logic        dx_pos;

    assign dx     = {1'b0, s5_xb_reg} - {1'b0, s5_xa_reg};
    assign dy     = {1'b0, s5_yb_reg} - {1'b0, s5_ya_reg};
    assign dy_neg = ~dy + 33'd1;
    assign dx_pos = ~dx[16] && (dx != 17'd0);

    stirr_pkg::side_t s6_side_reg;
    logic [15:0]      s6_de_reg;
    logic [31:0]      s6_mag_reg;
    logic [15:0]      s6_dx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_side_reg <= '0;
        end
        else
        begin
            s6_side_reg.vld  <= s5_vld_reg;
            s6_side_reg.kind <= s5_kind_reg;
            s6_side_reg.base <= s5_direct_reg | ~dx_pos;
            s6_side_reg.neg  <= dy[32];
            s6_side_reg.ya   <= s5_ya_reg;
            s6_side_reg.dens <= s5_dens_reg;
            s6_side_reg.b    <= s5_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_de_reg  <= s5_e_reg - s5_xa_reg;
        s6_mag_reg <= dy[32] ? dy_neg[31:0] : dy[31:0];
        s6_dx_reg  <= dx[15:0];
    end

    //------------------------------------------------------------------
    // S7: dividend = energy step * |rate step|
    //------------------------------------------------------------------
    stirr_pkg::side_t              s7_side_reg;
    logic [stirr_pkg::DIV_NW-1:0]  s7_num_reg;
    logic [stirr_pkg::DIV_DW-1:0]  s7_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_side_reg <= '0;
        end
        else
        begin
            s7_side_reg <= s6_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_num_reg <= 48'(s6_de_reg) * 48'(s6_mag_reg);
        s7_den_reg <= s6_dx_reg;
    end

    logic [stirr_pkg::DIV_NW-1:0] div_quo;
    stirr_pkg::side_t             div_side;

    stirr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .num      (s7_num_reg),
        .den      (s7_den_reg),
        .side_in  (s7_side_reg),
        .quo      (div_quo),
        .side_out (div_side)
    );

    //------------------------------------------------------------------
    // Interpolated rate, truncated toward zero, clamped to 32 bits
    //------------------------------------------------------------------
    logic signed [49:0] q_s;
    logic signed [49:0] r_sum;
    logic [31:0]        r_rate;

    assign q_s   = div_side.neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    assign r_sum = $signed({18'd0, div_side.ya}) + q_s;

    always_comb
    begin
        if (div_side.kind != stirr_pkg::KIND_EVAL)
        begin
            r_rate = 32'd0;
        end
        else if (div_side.base)
        begin
            r_rate = div_side.ya;
        end
        else if (r_sum < 0)
        begin
            r_rate = 32'd0;
        end
        else if (r_sum > $signed(50'h0_FFFF_FFFF))
        begin
            r_rate = 32'hFFFF_FFFF;
        end
        else
        begin
            r_rate = r_sum[31:0];
        end
    end

    logic        sr_vld_reg;
    logic [1:0]  sr_kind_reg;
    logic [31:0] sr_rate_reg;
    logic [31:0] sr_dens_reg;
    logic [63:0] sr_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_vld_reg <= 1'b0;
        end
        else
        begin
            sr_vld_reg <= div_side.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_kind_reg <= div_side.kind;
        sr_rate_reg <= r_rate;
        sr_dens_reg <= div_side.dens;
        sr_b_reg    <= div_side.b;
    end

    //------------------------------------------------------------------
    // Product: a = rate * density, then a * b as four 32x32 partials
    //------------------------------------------------------------------
    logic        m1_vld_reg;
    logic [1:0]  m1_kind_reg;
    logic [31:0] m1_rate_reg;
    logic [63:0] m1_a_reg;
    logic [63:0] m1_b_reg;

    logic        m2_vld_reg;
    logic [1:0]  m2_kind_reg;
    logic [31:0] m2_rate_reg;
    logic [63:0] m2_p00_reg;
    logic [63:0] m2_p01_reg;
    logic [63:0] m2_p10_reg;
    logic [63:0] m2_p11_reg;

    logic         m3_vld_reg;
    logic [1:0]   m3_kind_reg;
    logic [31:0]  m3_rate_reg;
    logic [127:0] m3_prod_reg;

    logic         sh_vld_reg;
    logic [1:0]   sh_kind_reg;
    logic [31:0]  sh_rate_reg;
    logic [127:0] sh_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            sh_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= sr_vld_reg;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            sh_vld_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_kind_reg <= sr_kind_reg;
        m1_rate_reg <= sr_rate_reg;
        m1_a_reg    <= 64'(sr_rate_reg) * 64'(sr_dens_reg);
        m1_b_reg    <= sr_b_reg;

        m2_kind_reg <= m1_kind_reg;
        m2_rate_reg <= m1_rate_reg;
        m2_p00_reg  <= 64'(m1_a_reg[31:0])  * 64'(m1_b_reg[31:0]);
        m2_p01_reg  <= 64'(m1_a_reg[31:0])  * 64'(m1_b_reg[63:32]);
        m2_p10_reg  <= 64'(m1_a_reg[63:32]) * 64'(m1_b_reg[31:0]);
        m2_p11_reg  <= 64'(m1_a_reg[63:32]) * 64'(m1_b_reg[63:32]);

        m3_kind_reg <= m2_kind_reg;
        m3_rate_reg <= m2_rate_reg;
        m3_prod_reg <= {m2_p11_reg, m2_p00_reg}
                     + (128'(m2_p01_reg) << 32)
                     + (128'(m2_p10_reg) << 32);

        sh_kind_reg <= m3_kind_reg;
        sh_rate_reg <= m3_rate_reg;
        sh_val_reg  <= m3_prod_reg >> shift_reg;
    end

    //------------------------------------------------------------------
    // Output word: saturate to 64 bits
    //------------------------------------------------------------------
    logic                 sat;
    logic                 result_valid_reg;
    stirr_pkg::out_word_t result_reg;

    assign sat = |sh_val_reg[127:64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= sh_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.rate_coefficient  <= sh_rate_reg;
        result_reg.reaction_progress <= sat ? '1 : sh_val_reg[63:0];
        if (sh_kind_reg == stirr_pkg::KIND_RANGE)
        begin
            result_reg.status <= stirr_pkg::ST_RANGE;
        end
        else if (sat)
        begin
            result_reg.status <= stirr_pkg::ST_SAT;
        end
        else
        begin
            result_reg.status <= stirr_pkg::ST_OK;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // every accepted word comes out after the fixed pipe depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("result strobe missing at fixed latency");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == stirr_pkg::ST_RANGE) |->
        (result.rate_coefficient == 32'd0 && result.reaction_progress == 64'd0))
        else $error("range error word carries nonzero data");

    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == stirr_pkg::ST_SAT) |->
        (result.reaction_progress == '1 && result.rate_coefficient != 32'd0))
        else $error("saturated word inconsistent");
`endif

endmodule
`default_nettype wire
